// ===== design/cspk_pkg.sv =====
// ----------------------------------------------------------------------------
// cspk_pkg
// Shared types, constants and character helpers for the callsign packer.
// ----------------------------------------------------------------------------
package cspk_pkg;

    localparam int unsigned NUM_NORM   = 6;
    localparam int unsigned NUM_RAW    = 3;
    localparam int unsigned NUM_DIGITS = 6;
    localparam int unsigned NUM_REGS   = 3;

    typedef logic [7:0]  char_t;
    typedef logic [31:0] word_t;
    typedef logic [5:0]  digit_t;
    typedef logic [2:0]  count_t;
    typedef logic [1:0]  reg_idx_t;

    localparam reg_idx_t REG_TOKEN_DE  = 2'd0;
    localparam reg_idx_t REG_TOKEN_QRZ = 2'd1;
    localparam reg_idx_t REG_TOKEN_CQ  = 2'd2;

    localparam word_t TOKEN_DE_RESET  = 32'd0;
    localparam word_t TOKEN_QRZ_RESET = 32'd1;
    localparam word_t TOKEN_CQ_RESET  = 32'd2;

    localparam count_t NORM_SAT = 3'd7;
    localparam count_t RAW_SAT  = 3'd4;

    localparam char_t CH_D = 8'h44;
    localparam char_t CH_E = 8'h45;
    localparam char_t CH_Q = 8'h51;
    localparam char_t CH_R = 8'h52;
    localparam char_t CH_Z = 8'h5A;
    localparam char_t CH_C = 8'h43;

    // mixed radix of the digits that follow the first one
    localparam digit_t RADIX_P2 = 6'd36;
    localparam digit_t RADIX_D  = 6'd10;
    localparam digit_t RADIX_S  = 6'd27;

    typedef struct packed {
        logic                         start;
        logic [NUM_DIGITS-1:0][5:0]   digits;   // [0] is the leading digit
    } pack_req_t;

    function automatic logic is_ws(input char_t c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_dig(input char_t c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_let(input char_t c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic char_t to_upper(input char_t c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? char_t'(c - 8'h20) : c;
    endfunction

    function automatic digit_t val_c1(input char_t c);
        digit_t v;
        v = 6'd0;
        if (is_dig(c))
        begin
            v = 6'(c - 8'h2F);
        end
        else if (is_let(c))
        begin
            v = 6'(c - 8'h36);
        end
        return v;
    endfunction

    function automatic digit_t val_c2(input char_t c);
        digit_t v;
        v = 6'd0;
        if (is_dig(c))
        begin
            v = 6'(c - 8'h30);
        end
        else if (is_let(c))
        begin
            v = 6'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic digit_t val_s(input char_t c);
        return is_let(c) ? 6'(c - 8'h40) : 6'd0;
    endfunction

    function automatic digit_t radix_of(input count_t step);
        digit_t r;
        case (step)
            3'd0:    r = RADIX_P2;
            3'd1:    r = RADIX_D;
            default: r = RADIX_S;
        endcase
        return r;
    endfunction

endpackage

// ===== design/cspk_ifs.sv =====
// ----------------------------------------------------------------------------
// cspk_ifs
// Valid/ready channels of the callsign packer: characters, results, config.
// ----------------------------------------------------------------------------
interface cspk_char_if;
    logic            valid;
    logic            ready;
    cspk_pkg::char_t char_code;
    logic            last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cspk_result_if;
    logic            valid;
    logic            ready;
    cspk_pkg::word_t packed_value;
    logic            accepted;

    modport source (output valid, output packed_value, output accepted, input ready);
    modport sink   (input valid, input packed_value, input accepted, output ready);
endinterface

interface cspk_cfg_if;
    logic               valid;
    logic               ready;
    cspk_pkg::reg_idx_t index;
    cspk_pkg::word_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/cspk_packer.sv =====
// ----------------------------------------------------------------------------
// cspk_packer
// Digit-serial mixed-radix packer: one digit folded in per cycle (Horner).
// ----------------------------------------------------------------------------
module cspk_packer
(
    input  logic                clk,
    input  logic                rst_n,
    input  cspk_pkg::pack_req_t req,
    output logic                done,
    output cspk_pkg::word_t     value
);
    import cspk_pkg::*;

    localparam count_t LAST_STEP = count_t'(NUM_DIGITS - 2);

    digit_t shift_reg [NUM_DIGITS-1];
    word_t  acc_reg;
    count_t step_reg;
    logic   busy_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= count_t'(step_reg + 3'd1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= {26'd0, req.digits[0]};
            for (int i = 0; i < NUM_DIGITS - 1; i++)
            begin
                shift_reg[i] <= req.digits[i+1];
            end
        end
        else if (busy_reg)
        begin
            acc_reg <= 32'(acc_reg * {26'd0, radix_of(step_reg)}) + {26'd0, shift_reg[0]};
            for (int i = 0; i < NUM_DIGITS - 2; i++)
            begin
                shift_reg[i] <= shift_reg[i+1];
            end
        end
    end

    assign done  = done_reg;
    assign value = acc_reg;

endmodule

// ===== design/callsign_pack_encoder.sv =====
// ----------------------------------------------------------------------------
// callsign_pack_encoder
// Packs a callsign, streamed one character per beat, into a 32-bit code.
// ----------------------------------------------------------------------------
// Channels: chars (sink) takes one raw ASCII character per beat, last_char
// on the final one; result (source) gives one beat per call: packed_value
// and accepted. cfg (sink) writes the DE, QRZ and CQ token codes at index
// 0, 1, 2; other indexes are ignored. cfg is always ready.
// Throughput: one character per cycle while a call is being collected.
// After the last character the block evaluates the call; for a standard
// call it then loads the serial packer, which folds the other five digits
// in at one multiply-add per cycle; the block then collects the sum and
// hands it over to the output register. chars is not ready from the last
// character until the result is loaded into the output register; the
// first character of the next call may follow then.
// The output register lets collection go on while a result is stalled; a
// finished result waits for the output register to free before the block
// returns to collecting.
// Reset: counts cleared, token codes return to 0, 1, 2, no result pending.
// ----------------------------------------------------------------------------
module callsign_pack_encoder
(
    input  logic          clk,
    input  logic          rst_n,
    cspk_char_if.sink     chars,
    cspk_result_if.source result,
    cspk_cfg_if.sink      cfg
);
    import cspk_pkg::*;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_EVAL,
        S_PACK,
        S_FINISH
    } state_t;

    state_t    state_reg;
    char_t     norm_reg [NUM_NORM];
    char_t     raw_reg  [NUM_RAW];
    count_t    ns_cnt_reg;
    count_t    raw_cnt_reg;
    word_t     tok_de_reg;
    word_t     tok_qrz_reg;
    word_t     tok_cq_reg;
    word_t     res_value_reg;
    logic      res_ok_reg;
    logic      out_valid_reg;
    word_t     out_value_reg;
    logic      out_ok_reg;

    logic      in_beat;
    logic      out_load;
    char_t     up_char;
    logic      nonspace;
    logic      is_tok_de;
    logic      is_tok_qrz;
    logic      is_tok_cq;
    logic      fit1;
    logic      fit2;
    logic      let_tail1;
    logic      let_tail2;
    logic      std_call;
    char_t     p0;
    char_t     p1;
    char_t     p2;
    char_t     sfx [3];
    pack_req_t req;
    logic      pack_done;
    word_t     pack_value;

    assign in_beat  = chars.valid && chars.ready;
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || result.ready);
    assign up_char  = to_upper(chars.char_code);
    assign nonspace = !is_ws(chars.char_code);

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            if (raw_cnt_reg < count_t'(NUM_RAW))
            begin
                raw_reg[raw_cnt_reg[1:0]] <= chars.char_code;
            end
            if (nonspace && (ns_cnt_reg < count_t'(NUM_NORM)))
            begin
                norm_reg[ns_cnt_reg] <= up_char;
            end
        end
    end

    // tokens are matched on the raw characters
    assign is_tok_de  = (raw_cnt_reg == 3'd2) && (raw_reg[0] == CH_D) && (raw_reg[1] == CH_E);
    assign is_tok_qrz = (raw_cnt_reg == 3'd3) && (raw_reg[0] == CH_Q) && (raw_reg[1] == CH_R)
                        && (raw_reg[2] == CH_Z);
    assign is_tok_cq  = (raw_cnt_reg == 3'd2) && (raw_reg[0] == CH_C) && (raw_reg[1] == CH_Q);

    always_comb
    begin
        let_tail1 = 1'b1;
        let_tail2 = 1'b1;
        for (int j = 2; j < NUM_NORM; j++)
        begin
            if ((count_t'(j) < ns_cnt_reg) && !is_let(norm_reg[j]))
            begin
                let_tail1 = 1'b0;
                if (j >= 3)
                begin
                    let_tail2 = 1'b0;
                end
            end
        end
    end

    // digit at place one or two, followed by one to three letters
    assign fit1 = (ns_cnt_reg >= 3'd3) && (ns_cnt_reg <= 3'd5) && is_dig(norm_reg[1])
                  && let_tail1;
    assign fit2 = (ns_cnt_reg >= 3'd4) && (ns_cnt_reg <= 3'd6) && is_dig(norm_reg[2])
                  && let_tail2;
    assign std_call = fit1 ? (is_dig(norm_reg[0]) || is_let(norm_reg[0]))
                           : (fit2 && (is_dig(norm_reg[0]) || is_let(norm_reg[0]))
                                   && (is_dig(norm_reg[1]) || is_let(norm_reg[1])));

    always_comb
    begin
        p0 = fit1 ? 8'h20 : norm_reg[0];
        p1 = fit1 ? norm_reg[0] : norm_reg[1];
        p2 = fit1 ? norm_reg[1] : norm_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            if (fit1)
            begin
                sfx[i] = (count_t'(2 + i) < ns_cnt_reg) ? norm_reg[2 + i] : 8'h20;
            end
            else
            begin
                sfx[i] = (count_t'(3 + i) < ns_cnt_reg) ? norm_reg[3 + i] : 8'h20;
            end
        end
        req.start     = (state_reg == S_EVAL) && !is_tok_de && !is_tok_qrz && !is_tok_cq
                        && std_call;
        req.digits[0] = val_c1(p0);
        req.digits[1] = val_c2(p1);
        req.digits[2] = {2'b00, p2[3:0]};
        req.digits[3] = val_s(sfx[0]);
        req.digits[4] = val_s(sfx[1]);
        req.digits[5] = val_s(sfx[2]);
    end

    cspk_packer u_packer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .done  (pack_done),
        .value (pack_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            ns_cnt_reg    <= '0;
            raw_cnt_reg   <= '0;
            tok_de_reg    <= TOKEN_DE_RESET;
            tok_qrz_reg   <= TOKEN_QRZ_RESET;
            tok_cq_reg    <= TOKEN_CQ_RESET;
            res_value_reg <= '0;
            res_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_TOKEN_DE:  tok_de_reg  <= cfg.data;
                    REG_TOKEN_QRZ: tok_qrz_reg <= cfg.data;
                    REG_TOKEN_CQ:  tok_cq_reg  <= cfg.data;
                    default:       ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_COLLECT:
                begin
                    if (in_beat)
                    begin
                        if (raw_cnt_reg < RAW_SAT)
                        begin
                            raw_cnt_reg <= count_t'(raw_cnt_reg + 3'd1);
                        end
                        if (nonspace && (ns_cnt_reg < NORM_SAT))
                        begin
                            ns_cnt_reg <= count_t'(ns_cnt_reg + 3'd1);
                        end
                        if (chars.last_char)
                        begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_EVAL:
                begin
                    ns_cnt_reg  <= '0;
                    raw_cnt_reg <= '0;
                    if (is_tok_de || is_tok_qrz || is_tok_cq)
                    begin
                        res_value_reg <= is_tok_de ? tok_de_reg
                                                   : (is_tok_qrz ? tok_qrz_reg : tok_cq_reg);
                        res_ok_reg    <= 1'b1;
                        state_reg     <= S_FINISH;
                    end
                    else if (std_call)
                    begin
                        state_reg <= S_PACK;
                    end
                    else
                    begin
                        res_value_reg <= '0;
                        res_ok_reg    <= 1'b0;
                        state_reg     <= S_FINISH;
                    end
                end
                S_PACK:
                begin
                    if (pack_done)
                    begin
                        res_value_reg <= pack_value;
                        res_ok_reg    <= 1'b1;
                        state_reg     <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_value_reg <= res_value_reg;
                        out_ok_reg    <= res_ok_reg;
                        state_reg     <= S_COLLECT;
                    end
                end
                default:
                begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    assign chars.ready         = (state_reg == S_COLLECT);
    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.packed_value = out_value_reg;
    assign result.accepted     = out_ok_reg;

endmodule

// ===== design/cspk_checker.sv =====
// ----------------------------------------------------------------------------
// cspk_checker
// Port-level checks on the callsign packer, bound to the top level.
// ----------------------------------------------------------------------------
module cspk_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_last,
    input logic            out_valid,
    input logic            out_ready,
    input cspk_pkg::word_t out_value,
    input logic            out_ok
);
    import cspk_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_ok))
        else $error("result beat dropped or changed while stalled");

    // a rejected call carries a zero code
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ok |-> out_value == 32'd0)
        else $error("rejected call with non-zero code");

    // after the last character the block stops taking characters
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("character taken straight after end of call");

    // character intake stays stopped after the last character while the call is still in evaluation
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> ##1 !(in_valid && in_ready))
        else $error("character taken during evaluation");

endmodule

bind callsign_pack_encoder cspk_checker u_cspk_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .in_last   (chars.last_char),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.packed_value),
    .out_ok    (result.accepted)
);
